FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks that are compiled in unless NO_ASSERTIONS is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// expression holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// consequence holds in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(label, clk, rst, expr, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

FILE: src/afcb_pkg.sv
// ----------------------------------------------------------------------------
// afcb_pkg
// shared constants, codes and arithmetic helpers of the cell box decoder
// ----------------------------------------------------------------------------
package afcb_pkg;

  // sizing of the class table and the grid
  localparam int MAX_CLASSES = 128;
  localparam int MAX_GRID    = 1024;

  localparam int CLS_W  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int CNT_W  = $clog2(MAX_CLASSES + 1);
  localparam int GRID_W = $clog2(MAX_GRID);
  localparam int LIM_W  = GRID_W + 1;

  // field widths of the ports
  localparam int Q_W           = 8;
  localparam int SCALE_W       = 16;
  localparam int SCORE_W       = 16;
  localparam int EDGE_W        = 24;
  localparam int CLASS_FIELD_W = 7;
  localparam int CELL_FIELD_W  = 10;
  localparam int STRIDE_W      = 8;
  localparam int GRID_REG_W    = 11;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  // datapath widths
  localparam int PROD_W = 26;                 // (q - zp) * scale, Q.12
  localparam int CTR_W  = GRID_W + STRIDE_W;  // counter * stride, pixels
  localparam int SUM_W  = ((CTR_W + 12) > EDGE_W ? CTR_W + 12 : EDGE_W) + 2;

  // request opcodes
  localparam logic [1:0] OP_LOGIT  = 2'd0;
  localparam logic [1:0] OP_DIST   = 2'd1;
  localparam logic [1:0] OP_THRESH = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_ZP  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCORE_SCL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_ZP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_SCL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STRIDE    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_W    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_H    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CLASSES   = 3'd7;

  // piecewise-linear sigmoid, Q.12 in, Q0.16 out, shifts and adds only
  function automatic logic [SCORE_W-1:0] sigmoid_q16(input logic signed [PROD_W-1:0] x);
    logic [PROD_W-1:0] a;
    logic [16:0]       y;
    a = x[PROD_W-1] ? PROD_W'(-x) : PROD_W'(x);
    if (a >= PROD_W'(20480)) begin
      y = 17'd65536;
    end else if (a >= PROD_W'(9728)) begin
      y = 17'(a[14:1]) + 17'd55296;
    end else if (a >= PROD_W'(4096)) begin
      y = 17'({a[13:0], 1'b0}) + 17'd40960;
    end else begin
      y = 17'({a[11:0], 2'b00}) + 17'd32768;
    end
    if (x[PROD_W-1]) begin
      y = 17'd65536 - y;
    end
    return y[16] ? {SCORE_W{1'b1}} : y[SCORE_W-1:0];
  endfunction

  // Q.12 to Q.8 with floor, then saturate to the edge width
  function automatic logic signed [EDGE_W-1:0] edge_q8_sat(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] sh;
    logic signed [EDGE_W-1:0] r;
    sh = v >>> 4;
    if (sh[SUM_W-1:EDGE_W-1] == '0 || sh[SUM_W-1:EDGE_W-1] == '1) begin
      r = sh[EDGE_W-1:0];
    end else if (sh[SUM_W-1]) begin
      r = {1'b1, {(EDGE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(EDGE_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

FILE: src/afcb_ram.sv
// ----------------------------------------------------------------------------
// afcb_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module afcb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 128
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds while not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/anchor_free_cell_box_decoder.sv
// ----------------------------------------------------------------------------
// anchor_free_cell_box_decoder
// quantized per-cell class scoring and distance-to-box decode
// ----------------------------------------------------------------------------
//  channel  direction  handshake                payload
//  in       sink       in_valid / in_ready      opcode, quant_value, threshold_*
//  out      source     out_valid / out_ready    box_*, best_class, best_score, cell_*
//  cfg      sink       cfg_valid / cfg_ready    cfg_index, cfg_data
//
//  one request is taken every cycle while in_ready is high; the fourth distance
//  passes the multiply, score/box and result registers, and out_valid rises
//  if the cell yields a box; a spare register behind the result register takes
//  a box while the sink stalls; the request side stops only while the spare is
//  full and the score/box stage holds another box; in_ready never looks at out_ready
//  reset clears the threshold valid bits; cfg_ready is high in every cycle
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module anchor_free_cell_box_decoder
  import afcb_pkg::*;
(
  input  logic                            clk,
  input  logic                            rst,
  // request channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      opcode,
  input  logic signed [Q_W-1:0]           quant_value,
  input  logic [CLASS_FIELD_W-1:0]        threshold_class,
  input  logic [SCORE_W-1:0]              threshold_value,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [EDGE_W-1:0]        box_left,
  output logic signed [EDGE_W-1:0]        box_top,
  output logic signed [EDGE_W-1:0]        box_right,
  output logic signed [EDGE_W-1:0]        box_bottom,
  output logic [CLASS_FIELD_W-1:0]        best_class,
  output logic [SCORE_W-1:0]              best_score,
  output logic [CELL_FIELD_W-1:0]         cell_column,
  output logic [CELL_FIELD_W-1:0]         cell_row,
  // configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [CFG_IDX_W-1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0]           cfg_data
);

  // one decoded box
  typedef struct packed {
    logic signed [EDGE_W-1:0]     left;
    logic signed [EDGE_W-1:0]     top;
    logic signed [EDGE_W-1:0]     right;
    logic signed [EDGE_W-1:0]     bottom;
    logic [CLASS_FIELD_W-1:0]     cls;
    logic [SCORE_W-1:0]           score;
    logic [CELL_FIELD_W-1:0]      col;
    logic [CELL_FIELD_W-1:0]      row;
  } result_t;

  // configuration registers
  logic signed [Q_W-1:0]      score_zero_point;
  logic [SCALE_W-1:0]         logit_scale;
  logic signed [Q_W-1:0]      box_zero_point;
  logic [SCALE_W-1:0]         dist_scale;
  logic [STRIDE_W-1:0]        cell_stride;
  logic [GRID_REG_W-1:0]      grid_width;
  logic [GRID_REG_W-1:0]      grid_height;
  logic [STRIDE_W-1:0]        class_count;

  // accept stage state
  logic [CNT_W-1:0]           class_cnt;
  logic [1:0]                 dist_cnt;
  logic [GRID_W-1:0]          col_cnt;
  logic [GRID_W-1:0]          row_cnt;
  logic [MAX_CLASSES-1:0]     thr_written;

  // multiply stage
  logic                       b_logit;
  logic                       b_dist;
  logic                       b_last;
  logic [1:0]                 b_didx;
  logic signed [Q_W-1:0]      b_q;
  logic [CLS_W-1:0]           b_cls;
  logic [GRID_W-1:0]          b_col;
  logic [GRID_W-1:0]          b_row;
  logic                       b_thr_written;
  logic [SCORE_W-1:0]         thr_rdata;

  // score / box stage
  logic                       c_logit;
  logic                       c_dist;
  logic                       c_last;
  logic [1:0]                 c_didx;
  logic signed [PROD_W-1:0]   c_prod;
  logic [SCORE_W-1:0]         c_thr;
  logic [CLS_W-1:0]           c_cls;
  logic [CTR_W-1:0]           c_cx;
  logic [CTR_W-1:0]           c_cy;
  logic [GRID_W-1:0]          c_col;
  logic [GRID_W-1:0]          c_row;

  // per-cell running state and distance store
  logic                       best_valid;
  logic [SCORE_W-1:0]         best_sc;
  logic [CLS_W-1:0]           best_cls;
  logic signed [PROD_W-1:0]   dstore [3];

  // handshake and control
  logic                       accept;
  logic                       advance;
  logic                       c_emit;
  logic [CNT_W-1:0]           count_eff;
  logic [LIM_W-1:0]           col_lim;
  logic [LIM_W-1:0]           row_lim;
  logic [LIM_W-1:0]           col_inc;
  logic [LIM_W-1:0]           row_inc;
  logic                       take_logit;
  logic                       thr_we;
  logic [CLS_W-1:0]           thr_raddr;

  // multiply stage datapath
  logic signed [Q_W:0]        diff;
  logic [SCALE_W-1:0]         mul_scale;
  logic signed [PROD_W-1:0]   prod;
  logic [CTR_W-1:0]           cx;
  logic [CTR_W-1:0]           cy;

  // score / box stage datapath
  logic [SCORE_W-1:0]         sig;
  logic                       wins;
  logic [CTR_W+11:0]          cx_q12;
  logic [CTR_W+11:0]          cy_q12;
  logic signed [SUM_W-1:0]    cx_s;
  logic signed [SUM_W-1:0]    cy_s;
  logic signed [EDGE_W-1:0]   l_edge;
  logic signed [EDGE_W-1:0]   t_edge;
  logic signed [EDGE_W-1:0]   r_edge;
  logic signed [EDGE_W-1:0]   b_edge;

  // result register and spare
  result_t                    res_new;
  result_t                    spare;
  logic                       spare_valid;
  logic                       out_free;

  // flow control: stall only when a new box finds the spare taken
  assign c_emit    = c_dist && c_last && best_valid && (r_edge > l_edge) && (b_edge > t_edge);
  assign advance   = !(spare_valid && c_emit);
  assign in_ready  = advance;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || out_ready;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      score_zero_point <= '0;
      logit_scale      <= SCALE_W'(4096);
      box_zero_point   <= '0;
      dist_scale       <= SCALE_W'(4096);
      cell_stride      <= STRIDE_W'(8);
      grid_width       <= GRID_REG_W'(80);
      grid_height      <= GRID_REG_W'(80);
      class_count      <= STRIDE_W'(80);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SCORE_ZP:  score_zero_point <= cfg_data[Q_W-1:0];
        REG_SCORE_SCL: logit_scale      <= cfg_data[SCALE_W-1:0];
        REG_BOX_ZP:    box_zero_point   <= cfg_data[Q_W-1:0];
        REG_BOX_SCL:   dist_scale       <= cfg_data[SCALE_W-1:0];
        REG_STRIDE:    cell_stride      <= cfg_data[STRIDE_W-1:0];
        REG_GRID_W:    grid_width       <= cfg_data[GRID_REG_W-1:0];
        REG_GRID_H:    grid_height      <= cfg_data[GRID_REG_W-1:0];
        REG_CLASSES:   class_count      <= cfg_data[STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  // effective limits
  always_comb begin
    count_eff = (int'(class_count) > MAX_CLASSES) ? CNT_W'(MAX_CLASSES) : CNT_W'(class_count);
    col_lim   = (int'(grid_width) > MAX_GRID) ? LIM_W'(MAX_GRID) : LIM_W'(grid_width);
    row_lim   = (int'(grid_height) > MAX_GRID) ? LIM_W'(MAX_GRID) : LIM_W'(grid_height);
    col_inc   = LIM_W'(col_cnt) + LIM_W'(1);
    row_inc   = LIM_W'(row_cnt) + LIM_W'(1);
  end

  // request decode at the accept edge
  assign take_logit = (opcode == OP_LOGIT) && (dist_cnt == 2'd0) && (class_cnt < count_eff);
  assign thr_we     = accept && (opcode == OP_THRESH) && (int'(threshold_class) < MAX_CLASSES);
  assign thr_raddr  = class_cnt[CLS_W-1:0];

  // threshold table
  afcb_ram #(
    .WIDTH (SCORE_W),
    .DEPTH (MAX_CLASSES)
  ) u_thr_ram (
    .clk   (clk),
    .we    (thr_we),
    .waddr (CLS_W'(threshold_class)),
    .wdata (threshold_value),
    .re    (accept),
    .raddr (thr_raddr),
    .rdata (thr_rdata)
  );

  // written flags of the threshold table, unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      thr_written <= '0;
    end else if (thr_we) begin
      thr_written[CLS_W'(threshold_class)] <= 1'b1;
    end
  end

  // cell sequencing counters
  always_ff @(posedge clk) begin
    if (rst) begin
      class_cnt <= '0;
      dist_cnt  <= '0;
      col_cnt   <= '0;
      row_cnt   <= '0;
    end else if (accept) begin
      if (take_logit) begin
        class_cnt <= class_cnt + CNT_W'(1);
      end
      if (opcode == OP_DIST) begin
        if (dist_cnt == 2'd3) begin
          dist_cnt  <= '0;
          class_cnt <= '0;
          if (col_inc >= col_lim) begin
            col_cnt <= '0;
            row_cnt <= (row_inc >= row_lim) ? '0 : row_inc[GRID_W-1:0];
          end else begin
            col_cnt <= col_inc[GRID_W-1:0];
          end
        end else begin
          dist_cnt <= dist_cnt + 2'd1;
        end
      end
    end
  end

  // accept -> multiply stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      b_logit <= 1'b0;
      b_dist  <= 1'b0;
      b_last  <= 1'b0;
    end else if (advance) begin
      b_logit <= accept && take_logit;
      b_dist  <= accept && (opcode == OP_DIST);
      b_last  <= accept && (opcode == OP_DIST) && (dist_cnt == 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_didx        <= dist_cnt;
      b_q           <= quant_value;
      b_cls         <= thr_raddr;
      b_col         <= col_cnt;
      b_row         <= row_cnt;
      b_thr_written <= thr_written[thr_raddr];
    end
  end

  // dequantize: one shared multiplier for logits and distances
  always_comb begin
    if (b_dist) begin
      diff      = (Q_W+1)'(b_q) - (Q_W+1)'(box_zero_point);
      mul_scale = dist_scale;
    end else begin
      diff      = (Q_W+1)'(b_q) - (Q_W+1)'(score_zero_point);
      mul_scale = logit_scale;
    end
    prod = PROD_W'(diff) * PROD_W'($signed({1'b0, mul_scale}));
    cx   = CTR_W'(b_col) * CTR_W'(cell_stride);
    cy   = CTR_W'(b_row) * CTR_W'(cell_stride);
  end

  // multiply -> score / box stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      c_logit <= 1'b0;
      c_dist  <= 1'b0;
      c_last  <= 1'b0;
    end else if (advance) begin
      c_logit <= b_logit;
      c_dist  <= b_dist;
      c_last  <= b_last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      c_didx <= b_didx;
      c_prod <= prod;
      c_thr  <= b_thr_written ? thr_rdata : '0;
      c_cls  <= b_cls;
      c_cx   <= cx;
      c_cy   <= cy;
      c_col  <= b_col;
      c_row  <= b_row;
    end
  end

  // class score and running best compare
  assign sig  = sigmoid_q16(c_prod);
  assign wins = c_logit && (sig > c_thr) && (sig > best_sc);

  always_ff @(posedge clk) begin
    if (rst) begin
      best_valid <= 1'b0;
      best_sc    <= '0;
      best_cls   <= '0;
    end else if (advance) begin
      if (c_dist && c_last) begin
        best_valid <= 1'b0;
        best_sc    <= '0;
        best_cls   <= '0;
      end else if (wins) begin
        best_valid <= 1'b1;
        best_sc    <= sig;
        best_cls   <= c_cls;
      end
    end
  end

  // first three distances of the cell
  always_ff @(posedge clk) begin
    if (advance && c_dist && !c_last) begin
      dstore[c_didx] <= c_prod;
    end
  end

  // box edges around the cell corner
  always_comb begin
    cx_q12 = {c_cx, 12'd0};
    cy_q12 = {c_cy, 12'd0};
    cx_s   = $signed(SUM_W'(cx_q12));
    cy_s   = $signed(SUM_W'(cy_q12));
    l_edge = edge_q8_sat(cx_s - SUM_W'(dstore[0]));
    t_edge = edge_q8_sat(cy_s - SUM_W'(dstore[1]));
    r_edge = edge_q8_sat(cx_s + SUM_W'(dstore[2]));
    b_edge = edge_q8_sat(cy_s + SUM_W'(c_prod));
  end

  // box of the finishing cell
  always_comb begin
    res_new.left   = l_edge;
    res_new.top    = t_edge;
    res_new.right  = r_edge;
    res_new.bottom = b_edge;
    res_new.cls    = CLASS_FIELD_W'(best_cls);
    res_new.score  = best_sc;
    res_new.col    = CELL_FIELD_W'(c_col);
    res_new.row    = CELL_FIELD_W'(c_row);
  end

  // spare register, holds a box while the result register waits
  always_ff @(posedge clk) begin
    if (rst) begin
      spare_valid <= 1'b0;
    end else if (out_free) begin
      spare_valid <= 1'b0;
    end else if (advance && c_emit) begin
      spare_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_free && advance && c_emit) begin
      spare <= res_new;
    end
  end

  // result register, the spare goes first
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= spare_valid || (advance && c_emit);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (spare_valid) begin
        box_left    <= spare.left;
        box_top     <= spare.top;
        box_right   <= spare.right;
        box_bottom  <= spare.bottom;
        best_class  <= spare.cls;
        best_score  <= spare.score;
        cell_column <= spare.col;
        cell_row    <= spare.row;
      end else if (advance && c_emit) begin
        box_left    <= res_new.left;
        box_top     <= res_new.top;
        box_right   <= res_new.right;
        box_bottom  <= res_new.bottom;
        best_class  <= res_new.cls;
        best_score  <= res_new.score;
        cell_column <= res_new.col;
        cell_row    <= res_new.row;
      end
    end
  end

  // checks
  `ASSERT_ALWAYS(a_stall_cause, clk, rst, in_ready || spare_valid, "input stalled without a waiting result")
  `ASSERT_ALWAYS(a_spare_held, clk, rst, !spare_valid || out_valid, "spare full behind an empty result register")
  `ASSERT_NEXT(a_no_spurious, clk, rst, !out_valid && !c_emit, !out_valid, "result raised without a finished cell")
  `ASSERT_ALWAYS(a_best_score, clk, rst, best_valid == (best_sc != '0), "running best flag and score disagree")
  `ASSERT_NEXT(a_cell_clear, clk, rst, advance && c_dist && c_last, !best_valid, "running best not cleared at cell end")

endmodule

FILE: tb/sv/anchor_free_cell_box_decoder_tb.sv
// ----------------------------------------------------------------------------
// anchor_free_cell_box_decoder_tb
// drives class logits, box distances and threshold loads into the cell box
// decoder under several register settings, keeps its own model of the cell
// scoring and box decode, and checks every decoded box field by field
// ----------------------------------------------------------------------------
module anchor_free_cell_box_decoder_tb;
  import afcb_pkg::*;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 8;

  // opcode the block has no use for
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic signed [Q_W-1:0]        logit_zp;
    logic [SCALE_W-1:0]           score_scl;
    logic signed [Q_W-1:0]        box_zp;
    logic [SCALE_W-1:0]           box_scl;
    logic [STRIDE_W-1:0]          stride;
    logic [GRID_REG_W-1:0]        grid_w;
    logic [GRID_REG_W-1:0]        grid_h;
    logic [7:0]                   classes;
  } decode_cfg_t;

  typedef struct packed {
    logic signed [EDGE_W-1:0]     x0;
    logic signed [EDGE_W-1:0]     y0;
    logic signed [EDGE_W-1:0]     x1;
    logic signed [EDGE_W-1:0]     y1;
    logic [CLASS_FIELD_W-1:0]     cls;
    logic [SCORE_W-1:0]           score;
    logic [CELL_FIELD_W-1:0]      col;
    logic [CELL_FIELD_W-1:0]      row;
  } cell_box_t;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  logic [1:0]                     opcode;
  logic signed [Q_W-1:0]          quant_value;
  logic [CLASS_FIELD_W-1:0]       threshold_class;
  logic [SCORE_W-1:0]             threshold_value;
  logic                           out_valid;
  logic                           out_ready;
  logic signed [EDGE_W-1:0]       box_left;
  logic signed [EDGE_W-1:0]       box_top;
  logic signed [EDGE_W-1:0]       box_right;
  logic signed [EDGE_W-1:0]       box_bottom;
  logic [CLASS_FIELD_W-1:0]       best_class;
  logic [SCORE_W-1:0]             best_score;
  logic [CELL_FIELD_W-1:0]        cell_column;
  logic [CELL_FIELD_W-1:0]        cell_row;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [CFG_IDX_W-1:0]           cfg_index;
  logic [CFG_DATA_W-1:0]          cfg_data;

  // model state
  decode_cfg_t                    cfg_now;
  logic [SCORE_W-1:0]             thr_table [MAX_CLASSES];
  int                             cur_col;
  int                             cur_row;
  int                             seen_classes;
  logic [SCORE_W-1:0]             top_score;
  logic [CLASS_FIELD_W-1:0]       top_class;
  bit                             top_found;
  int                             dist_seen;
  longint                         dist_held [3];

  cell_box_t                      pending_boxes [$];
  cell_box_t                      want_box;
  int                             fail_count = 0;
  int                             sent_items = 0;
  int                             cycle_count = 0;
  bit                             idling = 1'b1;

  anchor_free_cell_box_decoder i_dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .opcode          (opcode),
    .quant_value     (quant_value),
    .threshold_class (threshold_class),
    .threshold_value (threshold_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .box_left        (box_left),
    .box_top         (box_top),
    .box_right       (box_right),
    .box_bottom      (box_bottom),
    .best_class      (best_class),
    .best_score      (best_score),
    .cell_column     (cell_column),
    .cell_row        (cell_row),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------- model

  // shift-only sigmoid of a Q.12 logit, Q0.16 result
  function automatic logic [SCORE_W-1:0] logit_score(input longint x);
    longint a;
    longint y;
    a = (x < 0) ? -x : x;
    if (a >= 20480) begin
      y = 65536;
    end else if (a >= 9728) begin
      y = (a >>> 1) + 55296;
    end else if (a >= 4096) begin
      y = (a <<< 1) + 40960;
    end else begin
      y = (a <<< 2) + 32768;
    end
    if (x < 0) begin
      y = 65536 - y;
    end
    return (y > 65535) ? 16'hFFFF : 16'(y);
  endfunction

  // Q.12 to Q.8 floored, clamped to the edge range
  function automatic longint pixel_q8(input longint v);
    longint r;
    r = v >>> 4;
    if (r > 8388607) begin
      r = 8388607;
    end else if (r < -8388608) begin
      r = -8388608;
    end
    return r;
  endfunction

  function automatic int grid_limit(input logic [GRID_REG_W-1:0] reg_val);
    return (reg_val > MAX_GRID) ? MAX_GRID : int'(reg_val);
  endfunction

  function automatic void open_cell();
    seen_classes = 0;
    top_score    = '0;
    top_class    = '0;
    top_found    = 1'b0;
    dist_seen    = 0;
  endfunction

  // update the model with one accepted request, queue any box it yields
  function automatic void decode_request(input logic [1:0] op,
                                         input logic signed [Q_W-1:0] q,
                                         input logic [CLASS_FIELD_W-1:0] cls,
                                         input logic [SCORE_W-1:0] thr);
    longint    x;
    longint    d;
    longint    cx;
    longint    cy;
    longint    l;
    longint    t;
    longint    r;
    longint    b;
    int        class_lim;
    logic [SCORE_W-1:0] s;
    cell_box_t box;
    class_lim = (cfg_now.classes > MAX_CLASSES) ? MAX_CLASSES : int'(cfg_now.classes);
    case (op)
      OP_THRESH: begin
        thr_table[cls] = thr;
      end
      OP_LOGIT: begin
        // logits only count before the first distance of the cell
        if (dist_seen == 0 && seen_classes < class_lim) begin
          x = (longint'(q) - longint'($signed(cfg_now.logit_zp)))
              * longint'(cfg_now.score_scl);
          s = logit_score(x);
          if (s > thr_table[seen_classes] && s > top_score) begin
            top_score = s;
            top_class = CLASS_FIELD_W'(seen_classes);
            top_found = 1'b1;
          end
          seen_classes++;
        end
      end
      OP_DIST: begin
        d = (longint'(q) - longint'($signed(cfg_now.box_zp))) * longint'(cfg_now.box_scl);
        if (dist_seen < 3) begin
          dist_held[dist_seen] = d;
          dist_seen++;
        end else begin
          cx = longint'(cur_col) * longint'(cfg_now.stride) * 4096;
          cy = longint'(cur_row) * longint'(cfg_now.stride) * 4096;
          l  = pixel_q8(cx - dist_held[0]);
          t  = pixel_q8(cy - dist_held[1]);
          r  = pixel_q8(cx + dist_held[2]);
          b  = pixel_q8(cy + d);
          // no result without a class or for an empty box
          if (top_found && r > l && b > t) begin
            box.x0    = EDGE_W'(l);
            box.y0    = EDGE_W'(t);
            box.x1    = EDGE_W'(r);
            box.y1    = EDGE_W'(b);
            box.cls   = top_class;
            box.score = top_score;
            box.col   = CELL_FIELD_W'(cur_col);
            box.row   = CELL_FIELD_W'(cur_row);
            pending_boxes.insert(pending_boxes.size(), box);
          end
          // raster advance, column wraps into the next row
          cur_col++;
          if (cur_col >= grid_limit(cfg_now.grid_w)) begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= grid_limit(cfg_now.grid_h)) begin
              cur_row = 0;
            end
          end
          open_cell();
        end
      end
      default: begin
      end
    endcase
  endfunction

  // ---------------------------------------------------------------- drivers

  // send one request, leaving valid high so the next one can follow at once
  task automatic send_req(input logic [1:0] op, input logic [Q_W-1:0] q,
                          input logic [CLASS_FIELD_W-1:0] cls,
                          input logic [SCORE_W-1:0] thr);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    opcode          <= op;
    quant_value     <= q;
    threshold_class <= cls;
    threshold_value <= thr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_request(op, q, cls, thr);
    if (op != OP_SPARE) begin
      sent_items++;
    end
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // write every register, junk in the unused upper bits
  task automatic configure(input decode_cfg_t c);
    put_reg(REG_SCORE_ZP,  {8'($urandom), c.logit_zp});
    put_reg(REG_SCORE_SCL, c.score_scl);
    put_reg(REG_BOX_ZP,    {8'($urandom), c.box_zp});
    put_reg(REG_BOX_SCL,   c.box_scl);
    put_reg(REG_STRIDE,    {8'($urandom), c.stride});
    put_reg(REG_GRID_W,    {5'($urandom), c.grid_w});
    put_reg(REG_GRID_H,    {5'($urandom), c.grid_h});
    put_reg(REG_CLASSES,   {8'($urandom), c.classes});
    cfg_valid <= 1'b0;
    cfg_now = c;
  endtask

  // let every expected box come out, then let a cell with no box settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_boxes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // distance mostly above the zero point so boxes tend to be non-empty
  function automatic logic [Q_W-1:0] box_distance_q();
    int base;
    base = int'($signed(cfg_now.box_zp));
    if ($urandom_range(0, 3) == 0 || base == 127) begin
      return 8'($urandom);
    end
    return 8'(base + 1 + int'($urandom_range(0, 126 - base)));
  endfunction

  // spare opcode, stray logit or threshold load
  task automatic send_stray();
    case ($urandom_range(0, 2))
      0: send_req(OP_SPARE, 8'($urandom), 7'($urandom), 16'($urandom));
      1: send_req(OP_LOGIT, 8'($urandom), 7'($urandom), 16'($urandom));
      default: send_req(OP_THRESH, 8'($urandom), 7'($urandom),
                        $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 36000)));
    endcase
  endtask

  // one cell: some logits then four distances, with the odd stray request
  task automatic send_cell(input int max_logits);
    int n;
    n = ($urandom_range(0, 3) == 0) ? max_logits : int'($urandom_range(0, max_logits));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        send_stray();
      end
      send_req(OP_LOGIT, 8'($urandom), 7'($urandom), 16'($urandom));
    end
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_stray();
      end
      send_req(OP_DIST, box_distance_q(), 7'($urandom), 16'($urandom));
    end
  endtask

  task automatic run_cells(input int n_items, input int max_logits);
    int start;
    start = sent_items;
    while (sent_items - start < n_items) begin
      send_cell(max_logits);
    end
  endtask

  // ---------------------------------------------------------------- tests

  // hand-picked cells under the reset settings
  task automatic test_directed_cells();
    send_req(OP_THRESH, 8'($urandom), 7'd127, 16'hFFFF);
    send_req(OP_THRESH, 8'($urandom), 7'd0, 16'h8000);
    // score equal to threshold, lowest score, saturated score, tie with best
    send_req(OP_LOGIT, 8'sd0, 7'($urandom), 16'($urandom));
    send_req(OP_LOGIT, -8'sd128, 7'($urandom), 16'($urandom));
    send_req(OP_LOGIT, 8'sd127, 7'($urandom), 16'($urandom));
    send_req(OP_LOGIT, 8'sd127, 7'($urandom), 16'($urandom));
    send_req(OP_SPARE, 8'($urandom), 7'($urandom), 16'($urandom));
    repeat (4) send_req(OP_DIST, 8'sd127, 7'($urandom), 16'($urandom));
    // qualifying class but an inverted box
    send_req(OP_LOGIT, 8'sd127, 7'($urandom), 16'($urandom));
    send_req(OP_DIST, -8'sd128, 7'($urandom), 16'($urandom));
    send_req(OP_DIST, 8'sd0, 7'($urandom), 16'($urandom));
    send_req(OP_DIST, 8'sd0, 7'($urandom), 16'($urandom));
    send_req(OP_DIST, -8'sd128, 7'($urandom), 16'($urandom));
    // distances only, no class seen
    repeat (4) send_req(OP_DIST, 8'sd5, 7'($urandom), 16'($urandom));
    // weak logit, then a strong one after the first distance that must not count
    send_req(OP_LOGIT, -8'sd1, 7'($urandom), 16'($urandom));
    send_req(OP_DIST, 8'sd10, 7'($urandom), 16'($urandom));
    send_req(OP_LOGIT, 8'sd127, 7'($urandom), 16'($urandom));
    repeat (3) send_req(OP_DIST, 8'sd10, 7'($urandom), 16'($urandom));
  endtask

  // tight grid so rows and the whole grid wrap often
  task automatic test_small_grid();
    decode_cfg_t c;
    c.logit_zp  = 8'($urandom);
    c.score_scl = 16'($urandom_range(256, 12288));
    c.box_zp    = 8'($urandom);
    c.box_scl   = 16'($urandom_range(1024, 16384));
    c.stride    = 8'($urandom_range(1, 16));
    c.grid_w    = 11'd3;
    c.grid_h    = 11'd2;
    c.classes   = 8'd4;
    drain();
    configure(c);
    run_cells(100, 5);
  endtask

  // zero class count, zero grid limits, zero stride, extreme scales
  task automatic test_zero_limits();
    decode_cfg_t c;
    c.logit_zp  = -8'sd128;
    c.score_scl = 16'hFFFF;
    c.box_zp    = 8'sd127;
    c.box_scl   = 16'hFFFF;
    c.stride    = 8'd0;
    c.grid_w    = 11'd0;
    c.grid_h    = 11'd0;
    c.classes   = 8'd0;
    drain();
    configure(c);
    run_cells(40, 3);
  endtask

  // class count above the table size, flat scores, tall grid
  task automatic test_wide_class_count();
    decode_cfg_t c;
    c.logit_zp  = 8'sd127;
    c.score_scl = 16'd0;
    c.box_zp    = -8'sd128;
    c.box_scl   = 16'd1;
    c.stride    = 8'd128;
    c.grid_w    = 11'd2;
    c.grid_h    = 11'h7FF;
    c.classes   = 8'hFF;
    drain();
    configure(c);
    run_cells(150, 132);
  endtask

  // long row at a stride of 128 so edges grow large
  task automatic test_far_cells();
    decode_cfg_t c;
    c.logit_zp  = 8'($urandom);
    c.score_scl = 16'($urandom);
    c.box_zp    = 8'($urandom);
    c.box_scl   = 16'($urandom_range(8192, 65535));
    c.stride    = 8'd128;
    c.grid_w    = 11'd1024;
    c.grid_h    = 11'd3;
    c.classes   = 8'd1;
    drain();
    configure(c);
    send_req(OP_THRESH, 8'($urandom), 7'd0, 16'h4000);
    run_cells(300, 1);
  endtask

  // back-to-back traffic with both sides always ready
  task automatic test_steady_stream();
    decode_cfg_t c;
    c.logit_zp  = 8'($urandom);
    c.score_scl = 16'($urandom_range(0, 20000));
    c.box_zp    = 8'($urandom);
    c.box_scl   = 16'($urandom);
    c.stride    = 8'($urandom_range(1, 128));
    c.grid_w    = 11'd5;
    c.grid_h    = 11'd4;
    c.classes   = 8'd8;
    drain();
    configure(c);
    idling = 1'b0;
    run_cells(120, 10);
  endtask

  // ---------------------------------------------------------------- result side

  // result sink with random stall bursts
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // compare each accepted box with the oldest expected one
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_boxes.size() == 0) begin
        $error("box for cell %0d,%0d with none expected", cell_column, cell_row);
        fail_count++;
      end else begin
        want_box = pending_boxes.pop_front();
        if (box_left !== want_box.x0) begin
          $error("box_left: expected %0d, got %0d", want_box.x0, box_left);
          fail_count++;
        end
        if (box_top !== want_box.y0) begin
          $error("box_top: expected %0d, got %0d", want_box.y0, box_top);
          fail_count++;
        end
        if (box_right !== want_box.x1) begin
          $error("box_right: expected %0d, got %0d", want_box.x1, box_right);
          fail_count++;
        end
        if (box_bottom !== want_box.y1) begin
          $error("box_bottom: expected %0d, got %0d", want_box.y1, box_bottom);
          fail_count++;
        end
        if (best_class !== want_box.cls) begin
          $error("best_class: expected %0d, got %0d", want_box.cls, best_class);
          fail_count++;
        end
        if (best_score !== want_box.score) begin
          $error("best_score: expected %0d, got %0d", want_box.score, best_score);
          fail_count++;
        end
        if (cell_column !== want_box.col) begin
          $error("cell_column: expected %0d, got %0d", want_box.col, cell_column);
          fail_count++;
        end
        if (cell_row !== want_box.row) begin
          $error("cell_row: expected %0d, got %0d", want_box.row, cell_row);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin : run_tests
    in_valid        <= 1'b0;
    opcode          <= OP_LOGIT;
    quant_value     <= '0;
    threshold_class <= '0;
    threshold_value <= '0;
    cfg_valid       <= 1'b0;
    cfg_index       <= REG_SCORE_ZP;
    cfg_data        <= '0;
    rst             <= 1'b1;

    // model matches the block out of reset
    for (int i = 0; i < MAX_CLASSES; i++) begin
      thr_table[i] = '0;
    end
    for (int i = 0; i < 3; i++) begin
      dist_held[i] = 0;
    end
    cur_col           = 0;
    cur_row           = 0;
    open_cell();
    cfg_now.logit_zp  = 8'sd0;
    cfg_now.score_scl = 16'd4096;
    cfg_now.box_zp    = 8'sd0;
    cfg_now.box_scl   = 16'd4096;
    cfg_now.stride    = 8'd8;
    cfg_now.grid_w    = 11'd80;
    cfg_now.grid_h    = 11'd80;
    cfg_now.classes   = 8'd80;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed_cells();
    test_small_grid();
    test_zero_limits();
    test_wide_class_count();
    test_far_cells();
    test_steady_stream();
    drain();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: anchor_free_cell_box_decoder.f
+incdir+src
src/afcb_pkg.sv
src/afcb_ram.sv
src/anchor_free_cell_box_decoder.sv
tb/sv/anchor_free_cell_box_decoder_tb.sv
